// ----- rtl/flpt_pkg.sv -----
// Package for the FIFO lot profit-and-loss tracker: transaction structs
// and sequencer states. No dependencies.
`default_nettype none
package flpt_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [3:0]  buyer_slot;
        logic [3:0]  seller_slot;
        logic [31:0] mark_px;
        logic [63:0] trade_ref;
    } flpt_in_t;

    typedef struct packed {
        logic [3:0]  client_slot;
        logic [47:0] long_open_qty;
        logic [47:0] short_open_qty;
        logic [63:0] booked_pnl;
        logic [63:0] open_pnl;
        logic [63:0] net_cost_basis;
        logic [31:0] used_mark;
        logic [63:0] snapshot_trade;
        logic [31:0] win_count;
        logic [31:0] loss_count;
        logic        lot_overflow;
        logic        last;
    } flpt_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIDE,
        ST_CHK,
        ST_RDWAIT,
        ST_CLOSE_MUL,
        ST_CLOSE_UPD,
        ST_CLOSE_BAS,
        ST_OPEN,
        ST_OPEN_MUL,
        ST_UNR_L,
        ST_UNR_S,
        ST_EMIT
    } flpt_state_t;

endpackage
`default_nettype wire

// ----- rtl/flpt_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module flpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/flpt_mul.sv -----
// Shared 32x32 multiplier with registered product, used for every
// lot profit and basis product and the low part of each mark product. Depends on nothing.
`default_nettype none
module flpt_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);
    always_ff @(posedge clk)
    begin
        p <= {32'd0, a} * {32'd0, b};
    end
endmodule
`default_nettype wire

// ----- rtl/fifo_lot_pnl_tracker.sv -----
// FIFO lot profit-and-loss tracker top level. Uses flpt_pkg, flpt_ram, flpt_mul.
// Each side closes lots oldest first, one close round per lot, then opens and revalues;
// a skipped side moves straight on. Each snapshot strobes the cycle after its emit state.
// One transaction at a time; busy drops as the last snapshot strobes.
// Reset: clears per-client totals and queue heads/counts; lot RAM is not cleared.
// Snapshots strobe on valid for one cycle; the receiver cannot stall.
`default_nettype none
module fifo_lot_pnl_tracker
    import flpt_pkg::*;
#(
    parameter int CLIENT_SLOTS  = 16,
    parameter int LOTS_PER_SIDE = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire flpt_in_t  req,
    output logic           valid,
    output flpt_out_t      rsp
);
    localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int QW = SW + 1;
    localparam int NQ = CLIENT_SLOTS * 2;
    localparam int LW = (LOTS_PER_SIDE > 1) ? $clog2(LOTS_PER_SIDE) : 1;
    localparam int CW = $clog2(LOTS_PER_SIDE + 1);
    localparam int PW = CW + 1;
    localparam int AW = QW + LW;
    localparam int DEPTH = 1 << AW;

    flpt_state_t state_reg, state_next;

    logic [LW-1:0]  head_reg  [NQ];
    logic [CW-1:0]  cnt_reg   [NQ];
    logic [47:0]    ltot_reg  [CLIENT_SLOTS];
    logic [47:0]    stot_reg  [CLIENT_SLOTS];
    logic [63:0]    lbas_reg  [CLIENT_SLOTS];
    logic [63:0]    sbas_reg  [CLIENT_SLOTS];
    logic [63:0]    real_reg  [CLIENT_SLOTS];
    logic [31:0]    win_reg   [CLIENT_SLOTS];
    logic [31:0]    loss_reg  [CLIENT_SLOTS];

    flpt_in_t      in_reg;
    logic          side_reg;      // 0 buyer pass, 1 seller pass
    logic [31:0]   qty_reg;
    logic [31:0]   lq_reg, lp_reg, cl_reg;
    logic          ovf_reg;
    logic [63:0]   unr_reg;
    logic [31:0]   mark_reg;
    logic          valid_reg;
    flpt_out_t     rsp_reg;

    // current slot
    logic [3:0]    slot4;
    logic          slot_ok;
    logic [SW-1:0] slot;
    logic          buying;
    logic [QW-1:0] cq, oq;

    assign buying = ~side_reg;
    assign slot4  = side_reg ? in_reg.seller_slot : in_reg.buyer_slot;
    assign slot_ok = (slot4 != 4'd0) && ({28'd0, slot4} < 32'(CLIENT_SLOTS));
    assign slot   = SW'(slot4);
    assign cq     = {slot, buying};
    assign oq     = {slot, ~buying};

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    // tail position of the opening queue, wrapped without a divider
    logic [PW-1:0] open_sum;
    logic [LW-1:0] open_pos;
    assign open_sum = PW'(head_reg[oq]) + PW'(cnt_reg[oq]);
    assign open_pos = (open_sum >= PW'(LOTS_PER_SIDE)) ? LW'(open_sum - PW'(LOTS_PER_SIDE))
                                                       : LW'(open_sum);

    always_comb
    begin
        ram_raddr = AW'({cq, head_reg[cq]});
        ram_waddr = AW'({cq, head_reg[cq]});
        ram_wdata = {lp_reg, lq_reg - cl_reg};
        ram_we    = 1'b0;
        if (state_reg == ST_CLOSE_UPD)
        begin
            ram_we = (lq_reg != cl_reg);
        end
        else if (state_reg == ST_OPEN && cnt_reg[oq] < CW'(LOTS_PER_SIDE))
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'({oq, open_pos});
            ram_wdata = {in_reg.trade_price, qty_reg};
        end
    end

    flpt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_lots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // signed price difference: multiply the magnitude, restore the sign on the product
    logic [32:0] diff_w;
    logic        diff_neg;
    logic [31:0] diff_mag;
    assign diff_w   = buying ? ({1'b0, lp_reg} - {1'b0, in_reg.trade_price})
                             : ({1'b0, in_reg.trade_price} - {1'b0, lp_reg});
    assign diff_neg = diff_w[32];
    assign diff_mag = diff_neg ? 32'(33'd0 - diff_w) : diff_w[31:0];

    // shared multiplier operand selection
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        mul_a = cl_reg;
        mul_b = lp_reg;
        unique case (state_reg)
            ST_CLOSE_MUL: begin mul_a = cl_reg; mul_b = diff_mag; end
            ST_CLOSE_UPD: begin mul_a = cl_reg; mul_b = lp_reg; end
            ST_OPEN:      begin mul_a = qty_reg; mul_b = in_reg.trade_price; end
            ST_OPEN_MUL:  begin mul_a = mark_reg; mul_b = ltot_reg[slot][31:0]; end
            ST_UNR_L:     begin mul_a = mark_reg; mul_b = stot_reg[slot][31:0]; end
            default:      begin mul_a = mark_reg; mul_b = ltot_reg[slot][31:0]; end
        endcase
    end
    flpt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    // full 48x32 mark product: low 32 bits of total via multiplier plus high part
    logic [63:0] hi_l, hi_s;
    assign hi_l = {mark_reg * {16'd0, ltot_reg[slot][47:32]}, 32'd0};
    assign hi_s = {mark_reg * {16'd0, stot_reg[slot][47:32]}, 32'd0};

    logic last_now;
    logic seller_ok;
    assign seller_ok = (in_reg.seller_slot != 4'd0) &&
                       ({28'd0, in_reg.seller_slot} < 32'(CLIENT_SLOTS));
    assign last_now = side_reg || in_reg.mode || !seller_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = ST_SIDE;
            ST_SIDE:
                if (!slot_ok)
                    state_next = (side_reg || in_reg.mode) ? ST_IDLE : ST_SIDE;
                else if (in_reg.mode)
                    state_next = ST_OPEN_MUL;
                else
                    state_next = ST_CHK;
            ST_CHK:
                if (qty_reg != 32'd0 && cnt_reg[cq] != '0) state_next = ST_RDWAIT;
                else if (qty_reg != 32'd0) state_next = ST_OPEN;
                else state_next = ST_OPEN_MUL;
            ST_RDWAIT:    state_next = ST_CLOSE_MUL;
            ST_CLOSE_MUL: state_next = ST_CLOSE_UPD;
            ST_CLOSE_UPD: state_next = ST_CLOSE_BAS;
            ST_CLOSE_BAS: state_next = ST_CHK;
            ST_OPEN:      state_next = ST_OPEN_MUL;
            ST_OPEN_MUL:  state_next = ST_UNR_L;
            ST_UNR_L:     state_next = ST_UNR_S;
            ST_UNR_S:     state_next = ST_EMIT;
            ST_EMIT:      state_next = last_now ? ST_IDLE : ST_SIDE;
            default:      state_next = ST_IDLE;
        endcase
    end

    logic [63:0] prof;
    assign prof = diff_neg ? (64'd0 - mul_p) : mul_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            side_reg  <= 1'b0;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            for (int i = 0; i < CLIENT_SLOTS; i++)
            begin
                ltot_reg[i] <= '0; stot_reg[i] <= '0;
                lbas_reg[i] <= '0; sbas_reg[i] <= '0;
                real_reg[i] <= '0; win_reg[i]  <= '0; loss_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (start)
                    begin
                        in_reg   <= req;
                        side_reg <= 1'b0;
                        qty_reg  <= req.trade_qty;
                        ovf_reg  <= 1'b0;
                        mark_reg <= (req.mode || req.mark_px != 32'd0)
                                    ? req.mark_px : req.trade_price;
                    end
                ST_SIDE:
                    if (!slot_ok && !side_reg)
                        side_reg <= 1'b1;
                ST_RDWAIT:
                begin
                    lq_reg <= ram_rdata[31:0];
                    lp_reg <= ram_rdata[63:32];
                    cl_reg <= (qty_reg < ram_rdata[31:0]) ? qty_reg : ram_rdata[31:0];
                end
                ST_CLOSE_UPD:
                begin
                    real_reg[slot] <= real_reg[slot] + prof;
                    if (prof != 64'd0)
                    begin
                        if (prof[63]) loss_reg[slot] <= loss_reg[slot] + 32'd1;
                        else          win_reg[slot]  <= win_reg[slot] + 32'd1;
                    end
                    if (buying) stot_reg[slot] <= stot_reg[slot] - {16'd0, cl_reg};
                    else        ltot_reg[slot] <= ltot_reg[slot] - {16'd0, cl_reg};
                    qty_reg <= qty_reg - cl_reg;
                    if (lq_reg == cl_reg)
                    begin
                        head_reg[cq] <= (head_reg[cq] == LW'(LOTS_PER_SIDE - 1))
                                        ? '0 : head_reg[cq] + LW'(1);
                        cnt_reg[cq]  <= cnt_reg[cq] - CW'(1);
                    end
                end
                ST_CLOSE_BAS:
                    if (buying) sbas_reg[slot] <= sbas_reg[slot] - mul_p;
                    else        lbas_reg[slot] <= lbas_reg[slot] - mul_p;
                ST_OPEN:
                    if (cnt_reg[oq] < CW'(LOTS_PER_SIDE))
                    begin
                        cnt_reg[oq] <= cnt_reg[oq] + CW'(1);
                        if (buying) ltot_reg[slot] <= ltot_reg[slot] + {16'd0, qty_reg};
                        else        stot_reg[slot] <= stot_reg[slot] + {16'd0, qty_reg};
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                        qty_reg <= 32'd0;
                    end
                ST_OPEN_MUL:
                    if (qty_reg != 32'd0 && !in_reg.mode)
                    begin
                        if (buying) lbas_reg[slot] <= lbas_reg[slot] + mul_p;
                        else        sbas_reg[slot] <= sbas_reg[slot] + mul_p;
                    end
                ST_UNR_L:
                    unr_reg <= (ltot_reg[slot] != '0 && lbas_reg[slot] != '0 &&
                                !lbas_reg[slot][63])
                               ? (mul_p + hi_l - lbas_reg[slot]) : 64'd0;
                ST_UNR_S:
                    if (stot_reg[slot] != '0 && sbas_reg[slot] != '0 && !sbas_reg[slot][63])
                        unr_reg <= unr_reg + sbas_reg[slot] - (mul_p + hi_s);
                ST_EMIT:
                begin
                    valid_reg <= 1'b1;
                    rsp_reg.client_slot    <= slot4;
                    rsp_reg.long_open_qty  <= ltot_reg[slot];
                    rsp_reg.short_open_qty <= stot_reg[slot];
                    rsp_reg.booked_pnl     <= real_reg[slot];
                    rsp_reg.open_pnl       <= unr_reg;
                    rsp_reg.net_cost_basis <= lbas_reg[slot] - sbas_reg[slot];
                    rsp_reg.used_mark      <= mark_reg;
                    rsp_reg.snapshot_trade <= in_reg.mode ? 64'd0 : in_reg.trade_ref;
                    rsp_reg.win_count      <= win_reg[slot];
                    rsp_reg.loss_count     <= loss_reg[slot];
                    rsp_reg.lot_overflow   <= ovf_reg;
                    rsp_reg.last           <= last_now;
                    side_reg <= 1'b1;
                    qty_reg  <= in_reg.trade_qty;
                    ovf_reg  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign rsp   = rsp_reg;
endmodule
`default_nettype wire

// ----- rtl/flpt_checker.sv -----
// Port-level checker for fifo_lot_pnl_tracker, bound to the top level.
// Depends on flpt_pkg.
`default_nettype none
module flpt_checker
    import flpt_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      valid,
    input wire flpt_out_t rsp
);
    // accepted transaction raises busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy did not rise");
    // no snapshot while idle unless busy just fell
    a_val: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy)) else $error("snapshot without transaction");
    // snapshots are single-cycle strobes
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid) else $error("back to back snapshots");
    // last snapshot ends busy
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && rsp.last |-> !busy) else $error("busy after last");
    // never a snapshot for slot 0
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> rsp.client_slot != 4'd0) else $error("snapshot for slot 0");
endmodule

bind fifo_lot_pnl_tracker flpt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .valid(valid), .rsp(rsp)
);
`default_nettype wire

// ----- bench/fifo_lot_pnl_tracker_tb.sv -----
// Self-checking testbench for fifo_lot_pnl_tracker: drives trades and revaluations,
// predicts per-client FIFO lot snapshots and compares each strobed snapshot.
// Depends on flpt_pkg and the tracker RTL.
`timescale 1ns / 1ps
module fifo_lot_pnl_tracker_tb;
    import flpt_pkg::*;

    localparam int SLOTS = 16;
    localparam int LOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic MODE_TRADE = 1'b0;
    localparam logic MODE_REVALUE = 1'b1;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    flpt_in_t req;
    logic valid;
    flpt_out_t rsp;

    fifo_lot_pnl_tracker #(.CLIENT_SLOTS(SLOTS), .LOTS_PER_SIDE(LOTS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .valid(valid), .rsp(rsp)
    );

    // lot book model: queue index is slot*2 + side, side 1 is short
    logic [31:0] lot_qty [SLOTS*2][LOTS];
    logic [31:0] lot_px [SLOTS*2][LOTS];
    int unsigned q_head [SLOTS*2];
    int unsigned q_count [SLOTS*2];
    logic [47:0] pos_long [SLOTS];
    logic [47:0] pos_short [SLOTS];
    logic [63:0] basis_long [SLOTS];
    logic [63:0] basis_short [SLOTS];
    logic [63:0] pnl_booked [SLOTS];
    logic [31:0] wins [SLOTS];
    logic [31:0] losses [SLOTS];

    flpt_in_t pending_reqs [$];
    flpt_out_t expected_snaps [$];
    int errors;
    int gap_left;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic enqueue_req(input flpt_in_t t);
        pending_reqs.insert(pending_reqs.size(), t);
    endtask

    function automatic bit fill_side(input int slot, input bit buying,
                                     input logic [63:0] price, input logic [63:0] qty_in);
        int cq;
        int oq;
        int ix;
        logic [63:0] qty;
        logic [63:0] lq;
        logic [63:0] lp;
        logic [63:0] cl;
        logic [63:0] p;
        qty = qty_in;
        cq = slot * 2 + (buying ? 1 : 0);
        oq = slot * 2 + (buying ? 0 : 1);
        while (qty != 0 && q_count[cq] != 0)
        begin
            ix = q_head[cq];
            lq = {32'd0, lot_qty[cq][ix]};
            lp = {32'd0, lot_px[cq][ix]};
            cl = (qty < lq) ? qty : lq;
            p = (buying ? lp - price : price - lp) * cl;
            pnl_booked[slot] += p;
            if (p != 0)
            begin
                if (p[63]) losses[slot]++;
                else wins[slot]++;
            end
            if (buying)
            begin
                pos_short[slot] -= cl[47:0];
                basis_short[slot] -= lp * cl;
            end
            else
            begin
                pos_long[slot] -= cl[47:0];
                basis_long[slot] -= lp * cl;
            end
            lq -= cl;
            qty -= cl;
            if (lq == 0)
            begin
                q_head[cq] = (q_head[cq] + 1) % LOTS;
                q_count[cq]--;
            end
            else
                lot_qty[cq][ix] = lq[31:0];
        end
        if (qty != 0)
        begin
            if (q_count[oq] >= LOTS) return 1'b1;
            ix = (q_head[oq] + q_count[oq]) % LOTS;
            lot_qty[oq][ix] = qty[31:0];
            lot_px[oq][ix] = price[31:0];
            q_count[oq]++;
            if (buying)
            begin
                pos_long[slot] += qty[47:0];
                basis_long[slot] += price * qty;
            end
            else
            begin
                pos_short[slot] += qty[47:0];
                basis_short[slot] += price * qty;
            end
        end
        return 1'b0;
    endfunction

    function automatic flpt_out_t take_snapshot(input int slot, input logic [63:0] mark,
                                                input logic [63:0] ref_id, input bit ovf);
        flpt_out_t s;
        logic [63:0] u;
        u = 0;
        if (pos_long[slot] != 0 && basis_long[slot] != 0 && !basis_long[slot][63])
            u += mark * {16'd0, pos_long[slot]} - basis_long[slot];
        if (pos_short[slot] != 0 && basis_short[slot] != 0 && !basis_short[slot][63])
            u += basis_short[slot] - mark * {16'd0, pos_short[slot]};
        s.client_slot = slot[3:0];
        s.long_open_qty = pos_long[slot];
        s.short_open_qty = pos_short[slot];
        s.booked_pnl = pnl_booked[slot];
        s.open_pnl = u;
        s.net_cost_basis = basis_long[slot] - basis_short[slot];
        s.used_mark = mark[31:0];
        s.snapshot_trade = ref_id;
        s.win_count = wins[slot];
        s.loss_count = losses[slot];
        s.lot_overflow = ovf;
        s.last = 1'b0;
        return s;
    endfunction

    // queue the snapshots that one accepted transaction will produce
    task automatic predict_snapshots(input flpt_in_t t);
        logic [63:0] mark;
        int first;
        bit ovf;
        first = expected_snaps.size();
        if (t.mode == MODE_REVALUE)
        begin
            if (t.buyer_slot != 0)
                expected_snaps.insert(expected_snaps.size(),
                                      take_snapshot(t.buyer_slot, {32'd0, t.mark_px},
                                                    64'd0, 1'b0));
        end
        else
        begin
            mark = (t.mark_px == 0) ? {32'd0, t.trade_price} : {32'd0, t.mark_px};
            if (t.buyer_slot != 0)
            begin
                ovf = fill_side(t.buyer_slot, 1'b1, {32'd0, t.trade_price}, {32'd0, t.trade_qty});
                expected_snaps.insert(expected_snaps.size(),
                                      take_snapshot(t.buyer_slot, mark, t.trade_ref, ovf));
            end
            if (t.seller_slot != 0)
            begin
                ovf = fill_side(t.seller_slot, 1'b0, {32'd0, t.trade_price}, {32'd0, t.trade_qty});
                expected_snaps.insert(expected_snaps.size(),
                                      take_snapshot(t.seller_slot, mark, t.trade_ref, ovf));
            end
        end
        if (expected_snaps.size() > first)
            expected_snaps[expected_snaps.size()-1].last = 1'b1;
    endtask

    // driver: hold start until the transaction is taken, then draw a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            predict_snapshots(req);
            void'(pending_reqs.pop_front());
            start <= 1'b0;
            gap_left <= $urandom_range(0, 9);
        end
        else if (!start && gap_left > 0)
            gap_left <= gap_left - 1;
        else if (!start && pending_reqs.size() > 0)
        begin
            start <= 1'b1;
            req <= pending_reqs[0];
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_snaps.size() == 0)
                report("snapshot with no expectation");
            else
            begin
                flpt_out_t e;
                e = expected_snaps.pop_front();
                if (rsp.client_slot !== e.client_slot)
                    report($sformatf("client_slot %0d exp %0d", rsp.client_slot, e.client_slot));
                if (rsp.long_open_qty !== e.long_open_qty)
                    report($sformatf("long_open_qty %0d exp %0d", rsp.long_open_qty,
                                     e.long_open_qty));
                if (rsp.short_open_qty !== e.short_open_qty)
                    report($sformatf("short_open_qty %0d exp %0d", rsp.short_open_qty,
                                     e.short_open_qty));
                if (rsp.booked_pnl !== e.booked_pnl)
                    report($sformatf("booked_pnl %h exp %h", rsp.booked_pnl, e.booked_pnl));
                if (rsp.open_pnl !== e.open_pnl)
                    report($sformatf("open_pnl %h exp %h", rsp.open_pnl, e.open_pnl));
                if (rsp.net_cost_basis !== e.net_cost_basis)
                    report($sformatf("net_cost_basis %h exp %h", rsp.net_cost_basis,
                                     e.net_cost_basis));
                if (rsp.used_mark !== e.used_mark)
                    report($sformatf("used_mark %0d exp %0d", rsp.used_mark, e.used_mark));
                if (rsp.snapshot_trade !== e.snapshot_trade)
                    report($sformatf("snapshot_trade %h exp %h", rsp.snapshot_trade,
                                     e.snapshot_trade));
                if (rsp.win_count !== e.win_count)
                    report($sformatf("win_count %0d exp %0d", rsp.win_count, e.win_count));
                if (rsp.loss_count !== e.loss_count)
                    report($sformatf("loss_count %0d exp %0d", rsp.loss_count, e.loss_count));
                if (rsp.lot_overflow !== e.lot_overflow)
                    report($sformatf("lot_overflow %b exp %b", rsp.lot_overflow, e.lot_overflow));
                if (rsp.last !== e.last)
                    report($sformatf("last %b exp %b", rsp.last, e.last));
            end
        end
    end

    // watchdog: count cycles with no transaction accepted and no snapshot seen
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic flpt_in_t make_item(input logic m, input logic [31:0] px,
                                           input logic [31:0] qty, input logic [3:0] b,
                                           input logic [3:0] s, input logic [31:0] mk);
        flpt_in_t t;
        t.mode = m;
        t.trade_price = px;
        t.trade_qty = qty;
        t.buyer_slot = b;
        t.seller_slot = s;
        t.mark_px = mk;
        t.trade_ref = {$urandom, $urandom};
        return t;
    endfunction

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
            default: return 1000 + $urandom_range(0, 50);
        endcase
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 0;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    initial
    begin
        int i;
        int t_end;
        flpt_in_t t;
        errors = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, no client, same slot both sides, zero qty, queue full
        enqueue_req(make_item(MODE_TRADE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1, 4'd2, 0));
        enqueue_req(make_item(MODE_TRADE, 32'd0, 32'hFFFF_FFFF, 4'd2, 4'd1, 32'hFFFF_FFFF));
        enqueue_req(make_item(MODE_TRADE, 32'd100, 32'd5, 4'd0, 4'd0, 0));
        enqueue_req(make_item(MODE_TRADE, 32'd100, 32'd0, 4'd3, 4'd4, 0));
        enqueue_req(make_item(MODE_TRADE, 32'd50, 32'd10, 4'd5, 4'd5, 0));
        enqueue_req(make_item(MODE_REVALUE, 32'd0, 32'd0, 4'd1, 4'd0, 32'd0));
        enqueue_req(make_item(MODE_REVALUE, 32'd7, 32'd7, 4'd2, 4'd15, 32'hFFFF_FFFF));
        enqueue_req(make_item(MODE_REVALUE, 32'd7, 32'd7, 4'd0, 4'd3, 32'd9));
        for (i = 0; i < 17; i++)
            enqueue_req(make_item(MODE_TRADE, 32'd200 + i, 32'd3, 4'd15, 4'd0, 0));

        // random: small slot set so lots pile up and close against each other
        for (i = 0; i < 2000; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                t = make_item(MODE_REVALUE, $urandom, $urandom, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), rand_price());
            else
                t = make_item(MODE_TRADE, rand_price(), rand_qty(),
                              $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15)) :
                                                          4'($urandom_range(6, 9)),
                              $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15)) :
                                                          4'($urandom_range(6, 9)),
                              $urandom_range(0, 1) ? 32'd0 : rand_price());
            enqueue_req(t);
        end

        while (pending_reqs.size() > 0 || start) @(posedge clk);
        while (expected_snaps.size() > 0) @(posedge clk);
        t_end = 0;
        while (t_end < 200)
        begin
            @(posedge clk);
            t_end++;
        end
        if (errors == 0 && expected_snaps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/flpt_pkg.sv
rtl/flpt_ram.sv
rtl/flpt_mul.sv
rtl/fifo_lot_pnl_tracker.sv
rtl/flpt_checker.sv
bench/fifo_lot_pnl_tracker_tb.sv
